FILE: rtl/core/mesh_duplicate_forward_filter_macros.svh
// Assertion macros used by the port-level checker file.
`ifndef MESH_DUPLICATE_FORWARD_FILTER_MACROS_SVH
`define MESH_DUPLICATE_FORWARD_FILTER_MACROS_SVH

// Checked only while out of reset.
`define MDFF_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define MDFF_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/mdff_pkg.sv
// ----------------------------------------------------------------------------
// mdff_pkg
// Types and codes shared by the duplicate/hop-limit filter modules.
// ----------------------------------------------------------------------------
package mdff_pkg;

    localparam logic [1:0] VERDICT_FORWARD   = 2'd0;
    localparam logic [1:0] VERDICT_DUPLICATE = 2'd1;
    localparam logic [1:0] VERDICT_HOP_LIMIT = 2'd2;

    localparam logic [7:0] HOP_LIMIT_RESET = 8'd8;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic load_byte;    // fold a non-final byte into the running hash
        logic load_last;    // capture final hash and hops, start a lookup
        logic scan_step;    // issue the next ring read
        logic write_entry;  // store the hash and advance the ring pointer
        logic emit;         // load the result register
    } t_cmd;

    typedef struct packed {
        logic hop_lim;
        logic scan_end;
        logic match;
        logic out_free;
    } t_status;

endpackage

FILE: rtl/core/mdff_ram.sv
// ----------------------------------------------------------------------------
// mdff_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module mdff_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/core/mdff_ctrl.sv
// ----------------------------------------------------------------------------
// mdff_ctrl
// Sequencer: hashes bytes in idle, then scans, writes on a miss and emits per packet.
// ----------------------------------------------------------------------------
module mdff_ctrl import mdff_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_last_byte,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign accept = i_in_valid && (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && i_last_byte) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_status.hop_lim) begin
                    n_state = S_EMIT;
                end else if (i_status.scan_end) begin
                    n_state = i_status.match ? S_EMIT : S_WRITE;
                end
            end
            S_WRITE: n_state = S_EMIT;
            S_EMIT: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready        = 1'b1;
                o_cmd.load_byte   = accept && !i_last_byte;
                o_cmd.load_last   = accept && i_last_byte;
            end
            S_SCAN:  o_cmd.scan_step   = !i_status.hop_lim;
            S_WRITE: o_cmd.write_entry = 1'b1;
            S_EMIT:  o_cmd.emit        = i_status.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

FILE: rtl/core/mdff_dp.sv
// ----------------------------------------------------------------------------
// mdff_dp
// Datapath: running hash, recent-hash ring with fill count, result register.
// ----------------------------------------------------------------------------
module mdff_dp import mdff_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    input  logic [7:0]  i_data_byte,
    input  logic [7:0]  i_hop_count,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output logic [1:0]  o_verdict,
    output logic [7:0]  o_next_hops,
    output logic [31:0] o_packet_hash
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [31:0]      r_hash;
    logic [31:0]      n_hash;
    logic [31:0]      r_final_hash;
    logic [7:0]       r_hops;
    logic [7:0]       r_hop_limit;
    logic             r_hop_lim;
    logic             r_match;
    logic [PTR_W-1:0] r_ptr;
    logic [CNT_W-1:0] r_fill;
    logic [CNT_W-1:0] r_idx;
    logic             r_rd_vld;
    logic             r_out_valid;
    logic [1:0]       r_verdict;
    logic [7:0]       r_next_hops;
    logic [31:0]      r_out_hash;
    logic [31:0]      rd_data;
    logic             more;
    logic             issue;
    logic [1:0]       verdict;

    // h*31 + byte as a shift and subtract
    assign n_hash  = {r_hash[26:0], 5'b0} - r_hash + {24'b0, i_data_byte};
    assign more    = r_idx < r_fill;
    assign issue   = i_cmd.scan_step && more;
    assign verdict = r_hop_lim ? VERDICT_HOP_LIMIT :
                     r_match   ? VERDICT_DUPLICATE : VERDICT_FORWARD;

    mdff_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.write_entry),
        .i_wr_addr (r_ptr),
        .i_wr_data (r_final_hash),
        .i_rd_addr (r_idx[PTR_W-1:0]),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash      <= '0;
            r_ptr       <= '0;
            r_fill      <= '0;
            r_hop_limit <= HOP_LIMIT_RESET;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_hop_limit <= i_cfg_data;
            end
            if (i_cmd.load_byte) begin
                r_hash <= n_hash;
            end else if (i_cmd.load_last) begin
                r_hash <= '0;
            end
            r_rd_vld <= issue;
            if (i_cmd.write_entry) begin
                r_ptr <= (r_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_ptr + 1'b1;
                if (r_fill != CNT_W'(DEPTH)) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_last) begin
            r_final_hash <= n_hash;
            r_hops       <= i_hop_count;
            r_hop_lim    <= i_hop_count >= r_hop_limit;
            r_idx        <= '0;
            // never-written ring slots are not cleared and count as a zero hash
            r_match      <= (r_fill != CNT_W'(DEPTH)) && (n_hash == 32'd0);
        end else begin
            if (issue) begin
                r_idx <= r_idx + 1'b1;
            end
            if (r_rd_vld && (rd_data == r_final_hash)) begin
                r_match <= 1'b1;
            end
        end
        if (i_cmd.emit) begin
            r_verdict   <= verdict;
            r_next_hops <= (verdict == VERDICT_FORWARD) ? r_hops + 8'd1 : r_hops;
            r_out_hash  <= r_final_hash;
        end
    end

    assign o_status.hop_lim  = r_hop_lim;
    assign o_status.scan_end = r_match || (!more && !r_rd_vld);
    assign o_status.match    = r_match;
    assign o_status.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_verdict     = r_verdict;
    assign o_next_hops   = r_next_hops;
    assign o_packet_hash = r_out_hash;

endmodule

FILE: rtl/core/mesh_duplicate_forward_filter.sv
// Input: non-final bytes are taken back to back while idle; after a final byte the
// input is held off until its result is emitted. On a hop-limit drop the ring is
// not read; otherwise the ring is read one entry per cycle through the single RAM
// read port, over the entries filled so far, ending the scan on a match.
// Reset: synchronous, clears hash, ring pointer and fill count; no clearing pass,
// slots not yet filled count as zero. The hop limit resets to 8.
// ----------------------------------------------------------------------------
// mesh_duplicate_forward_filter
// Per-packet hash, hop limit check and recent-hash duplicate filter.
// ----------------------------------------------------------------------------
module mesh_duplicate_forward_filter import mdff_pkg::*; #(
    parameter int RECENT_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic [7:0]  i_hop_count,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_verdict,
    output logic [7:0]  o_next_hops,
    output logic [31:0] o_packet_hash,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    mdff_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_last_byte (i_last_byte),
        .i_status    (status),
        .o_in_ready  (o_in_ready),
        .o_cmd       (cmd)
    );

    mdff_dp #(
        .DEPTH (RECENT_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_data_byte   (i_data_byte),
        .i_hop_count   (i_hop_count),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_verdict     (o_verdict),
        .o_next_hops   (o_next_hops),
        .o_packet_hash (o_packet_hash)
    );

endmodule

FILE: rtl/core/mdff_checker.sv
// ----------------------------------------------------------------------------
// mdff_checker
// Port-level checks for the duplicate/hop-limit filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "mesh_duplicate_forward_filter_macros.svh"

module mdff_checker import mdff_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [7:0]  i_data_byte,
    input logic        i_last_byte,
    input logic [7:0]  i_hop_count,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_verdict,
    input logic [7:0]  o_next_hops,
    input logic [31:0] o_packet_hash
);

    `MDFF_ASSERT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")

    `MDFF_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_verdict) && $stable(o_next_hops) && $stable(o_packet_hash), "stalled result changed")

    // a waiting input word keeps its payload
    `MDFF_ASSERT(a_in_hold, i_clk, i_rst_n, i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_data_byte) && $stable(i_last_byte) && $stable(i_hop_count), "waiting input word changed")

    // a forwarded word carries hops+1, which cannot wrap to zero
    `MDFF_ASSERT(a_fwd_hops, i_clk, i_rst_n, o_out_valid && (o_verdict == VERDICT_FORWARD) |-> o_next_hops != 8'd0, "forward with zero hops")

    // the lookup after a final byte holds off the input side
    `MDFF_ASSERT(a_busy_after_last, i_clk, i_rst_n, i_in_valid && o_in_ready && i_last_byte |=> !o_in_ready, "input ready during lookup")

endmodule

bind mesh_duplicate_forward_filter mdff_checker u_mdff_checker (.*);

FILE: dv/mdff_verdict_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mdff_verdict_checker
// Tracks the running packet hash, the recent-hash ring and the hop limit from
// the accepted words, predicts one verdict per final byte and checks each result
// word against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module mdff_verdict_checker import mdff_pkg::*; #(
    parameter int RECENT_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic [7:0]  i_hop_count,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [1:0]  i_verdict,
    input  logic [7:0]  i_next_hops,
    input  logic [31:0] i_packet_hash,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [7:0]  i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    localparam logic [31:0] HASH_MULT = 32'd31;

    typedef struct packed {
        logic [1:0]  verdict;
        logic [7:0]  next_hops;
        logic [31:0] packet_hash;
    } t_verdict_word;

    logic [7:0]    hop_limit;
    logic [31:0]   running_hash;
    logic [31:0]   recent_ring [RECENT_DEPTH];
    int            ring_ptr;
    t_verdict_word expected_verdicts [$];
    int            fail_count = 0;

    // Applies the hop limit and the ring lookup; a miss claims the next ring slot.
    function automatic t_verdict_word close_packet(input logic [31:0] hash,
                                                   input logic [7:0] hops);
        t_verdict_word w;
        logic          seen;
        w.packet_hash = hash;
        w.next_hops   = hops;
        seen          = 1'b0;
        if (hops >= hop_limit) begin
            w.verdict = VERDICT_HOP_LIMIT;
        end else begin
            foreach (recent_ring[i]) begin
                if (recent_ring[i] == hash) begin
                    seen = 1'b1;
                end
            end
            if (seen) begin
                w.verdict = VERDICT_DUPLICATE;
            end else begin
                recent_ring[ring_ptr] = hash;
                ring_ptr    = (ring_ptr + 1) % RECENT_DEPTH;
                w.verdict   = VERDICT_FORWARD;
                w.next_hops = hops + 8'd1;
            end
        end
        return w;
    endfunction

    always @(posedge i_clk) begin : track
        t_verdict_word want;
        logic [31:0]   folded;
        if (!i_rst_n) begin
            hop_limit    = HOP_LIMIT_RESET;
            running_hash = '0;
            ring_ptr     = 0;
            foreach (recent_ring[i]) begin
                recent_ring[i] = '0;
            end
            expected_verdicts.delete();
        end else begin
            // a result can never come from a word taken at the same edge
            if (i_out_valid && i_out_ready) begin
                if (expected_verdicts.size() == 0) begin
                    $display("%0t unexpected result word: verdict %0d hops %0d hash %08h",
                             $time, i_verdict, i_next_hops, i_packet_hash);
                    fail_count++;
                end else begin
                    want = expected_verdicts.pop_front();
                    if (i_verdict !== want.verdict) begin
                        $display("%0t verdict mismatch: expected %0d, actual %0d",
                                 $time, want.verdict, i_verdict);
                        fail_count++;
                    end
                    if (i_next_hops !== want.next_hops) begin
                        $display("%0t next_hops mismatch: expected %0d, actual %0d",
                                 $time, want.next_hops, i_next_hops);
                        fail_count++;
                    end
                    if (i_packet_hash !== want.packet_hash) begin
                        $display("%0t packet_hash mismatch: expected %08h, actual %08h",
                                 $time, want.packet_hash, i_packet_hash);
                        fail_count++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                hop_limit = i_cfg_data;
            end
            if (i_in_valid && i_in_ready) begin
                folded = running_hash * HASH_MULT + {24'd0, i_data_byte};
                if (i_last_byte) begin
                    running_hash = '0;
                    want = close_packet(folded, i_hop_count);
                    expected_verdicts.insert(expected_verdicts.size(), want);
                end else begin
                    running_hash = folded;
                end
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= expected_verdicts.size();
    end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Duplicate/hop-limit filter test: directed packets for the edge cases, then
// random packets (fresh, replayed and truncated) over several hop limit
// settings, with bursty input and a stalling result side.
// ----------------------------------------------------------------------------
module tb;
    import mdff_pkg::*;

    localparam int RECENT_DEPTH = 16;
    localparam int ITEM_TARGET  = 550;
    localparam int PHASES       = 5;
    localparam int MAX_PKT      = 24;
    localparam int HIST_DEPTH   = 16;
    localparam int DRAIN_CYCLES = RECENT_DEPTH + 8;
    localparam int CYCLE_LIMIT  = 200000;

    typedef enum int {
        READY_ALWAYS,
        READY_HALF,
        READY_MOSTLY,
        READY_RARE
    } t_ready_mode;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_data_byte = '0;
    logic        i_last_byte = 1'b0;
    logic [7:0]  i_hop_count = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_verdict;
    logic [7:0]  o_next_hops;
    logic [31:0] o_packet_hash;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data = '0;

    int          fail_count;
    int          pending;
    int          cycle_count;
    int          items_sent = 0;
    int          burst_left = 0;
    logic        gaps_on = 1'b1;
    logic [7:0]  cur_hop_limit = HOP_LIMIT_RESET;

    logic [7:0]  pkt_bytes [MAX_PKT];
    int          pkt_len;
    logic [7:0]  hist_bytes [HIST_DEPTH][MAX_PKT];
    int          hist_len [HIST_DEPTH];
    int          hist_fill = 0;
    int          hist_wr = 0;

    t_ready_mode ready_mode = READY_ALWAYS;
    int          mode_left = 0;

    mesh_duplicate_forward_filter #(
        .RECENT_DEPTH(RECENT_DEPTH)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_data_byte  (i_data_byte),
        .i_last_byte  (i_last_byte),
        .i_hop_count  (i_hop_count),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_verdict    (o_verdict),
        .o_next_hops  (o_next_hops),
        .o_packet_hash(o_packet_hash),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    mdff_verdict_checker #(
        .RECENT_DEPTH(RECENT_DEPTH)
    ) verdict_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_data_byte  (i_data_byte),
        .i_last_byte  (i_last_byte),
        .i_hop_count  (i_hop_count),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_verdict    (o_verdict),
        .i_next_hops  (o_next_hops),
        .i_packet_hash(o_packet_hash),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // result side: random stall pattern, switched when its run counter expires
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            ready_mode <= t_ready_mode'($urandom_range(0, 3));
            mode_left  <= $urandom_range(20, 120);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (ready_mode)
            READY_ALWAYS: i_out_ready <= 1'b1;
            READY_HALF:   i_out_ready <= 1'($urandom_range(0, 1));
            READY_MOSTLY: i_out_ready <= ($urandom_range(0, 7) != 0);
            default:      i_out_ready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    task automatic send_word(input logic [7:0] b, input logic last, input logic [7:0] hops);
        int gap;
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= last;
        i_hop_count <= hops;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 15);
            gap = gaps_on ? $urandom_range(0, 6) : 0;
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // hop count only matters on the final byte; others get noise
    task automatic send_packet(input logic [7:0] hops);
        for (int k = 0; k < pkt_len; k++) begin
            send_word(pkt_bytes[k], k == pkt_len - 1,
                      (k == pkt_len - 1) ? hops : 8'($urandom));
        end
    endtask

    task automatic one_byte(input logic [7:0] b, input logic [7:0] hops);
        pkt_len      = 1;
        pkt_bytes[0] = b;
        send_packet(hops);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        // a trailing non-final byte may still be in flight
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_hop_limit(input logic [7:0] value);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid   <= 1'b0;
        cur_hop_limit = value;
    endtask

    function automatic logic [7:0] pick_hops();
        int r;
        r = $urandom_range(0, 99);
        if (cur_hop_limit != 0 && r < 70) begin
            return 8'($urandom_range(0, cur_hop_limit - 1));
        end
        if (r < 85) begin
            return cur_hop_limit;
        end
        return 8'($urandom);
    endfunction

    // mostly well-formed packets, some replays to hit the ring, some truncated
    task automatic build_packet();
        int r;
        int src;
        r = $urandom_range(0, 99);
        if (r < 25 && hist_fill > 0) begin
            src     = $urandom_range(0, hist_fill - 1);
            pkt_len = hist_len[src];
            for (int k = 0; k < pkt_len; k++) begin
                pkt_bytes[k] = hist_bytes[src][k];
            end
        end else begin
            pkt_len = (r < 88) ? 8 + $urandom_range(0, MAX_PKT - 8) : $urandom_range(1, 7);
            for (int k = 0; k < pkt_len; k++) begin
                if (r >= 97) begin
                    pkt_bytes[k] = 8'h00;
                end else if (k < 8 && r < 60) begin
                    pkt_bytes[k] = 8'($urandom_range(0, 3));
                end else begin
                    pkt_bytes[k] = 8'($urandom);
                end
            end
            hist_len[hist_wr] = pkt_len;
            for (int k = 0; k < pkt_len; k++) begin
                hist_bytes[hist_wr][k] = pkt_bytes[k];
            end
            hist_wr = (hist_wr + 1) % HIST_DEPTH;
            if (hist_fill < HIST_DEPTH) begin
                hist_fill++;
            end
        end
    endtask

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        logic [7:0] phase_max [PHASES];
        int         phase_end;
        int         phase_mid;
        logic       held;
        phase_max = '{8'd8, 8'd255, 8'd0, 8'd1, 8'd8};
        phase_max[PHASES - 1] = 8'($urandom_range(2, 254));
        held = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // hash of zero matches the never-written ring slots
        one_byte(8'h00, 8'd0);
        for (int k = 0; k < 8; k++) begin
            pkt_bytes[k] = 8'(k + 1);
        end
        pkt_bytes[8] = 8'hFF;
        pkt_len      = 9;
        send_packet(8'd0);
        one_byte(8'hAB, 8'd7);
        one_byte(8'hAB, 8'd7);
        one_byte(8'h55, 8'd8);
        one_byte(8'hFF, 8'd255);
        write_hop_limit(8'd255);
        one_byte(8'h12, 8'd254);
        write_hop_limit(8'd0);
        one_byte(8'h34, 8'd0);
        one_byte(8'hFF, 8'd255);
        write_hop_limit(8'd1);
        one_byte(8'h56, 8'd0);
        one_byte(8'h78, 8'd1);

        for (int p = 0; p < PHASES; p++) begin
            write_hop_limit(phase_max[p]);
            gaps_on   = (p != 3);
            phase_end = items_sent + (ITEM_TARGET - items_sent) / (PHASES - p);
            phase_mid = (items_sent + phase_end) / 2;
            while (items_sent < phase_end) begin
                if (p == 1 && !held && items_sent >= phase_mid) begin
                    wait_drained();
                    held = 1'b1;
                end
                build_packet();
                send_packet(pick_hops());
            end
        end

        wait_drained();
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
